// ===== src/fccw_pkg.sv =====
`default_nettype none

package fccw_pkg;

    // field widths
    localparam int CL_W     = 16;
    localparam int BLK_W    = 25;
    localparam int BADDR_W  = 17;
    localparam int ADDR_W   = 18;
    localparam int CFG_W    = 24;
    localparam int VIS_W    = 17;
    localparam int SPC_W    = 7;
    localparam int PROD_W   = CL_W + SPC_W;

    // parameter defaults
    localparam int FAT_STORE_BYTES_DEF    = 131072;
    localparam int MAX_CLUSTER_BLOCKS_DEF = 64;

    // end of chain masks and entry masks
    localparam logic [CL_W-1:0] EOC_MASK12   = 16'h0ff8;
    localparam logic [CL_W-1:0] EOC_MASK16   = 16'hfff8;
    localparam logic [CL_W-1:0] ENTRY_MASK12 = 16'h0fff;
    localparam logic [CL_W-1:0] ENTRY_MASK16 = 16'hffff;

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CONT  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD      = 2'd1;
    localparam logic [1:0] STAT_NO_CHAIN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FAT16     = 2'd0;
    localparam logic [1:0] CFG_SPC       = 2'd1;
    localparam logic [1:0] CFG_DATA_BASE = 2'd2;
    localparam logic [1:0] CFG_CL_COUNT  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BADDR_W-1:0] byte_address;
        logic [7:0]         byte_value;
        logic [CL_W-1:0]    start_cluster;
    } t_item;

    typedef struct packed {
        logic [BLK_W-1:0] block_number;
        logic [1:0]       status;
        logic             end_of_chain;
        logic             last_of_run;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD1,
        ST_RD2,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/fat_cluster_chain_walker_top.sv =====
`default_nettype none

// FAT cluster chain walker
// Input words are taken on start while busy is low. A load word writes one raw
// FAT byte into the local store and gives no result. A start word opens a chain
// at start_cluster and walks it; a continue word walks the next cluster of the
// open chain. Each walk emits the device blocks of the current cluster, one
// result word per cycle on o_result marked by o_strobe, the final one with
// last_of_run set. Results cannot be held off.
// A walk goes through the check, RD1 and RD2 states and then the emit state once
// per block, and busy stays high until the last block is emitted. The steps
// are set by the single read port of the FAT store (two byte reads) and the
// shared adder that forms the read address, the cluster base and each block
// number in turn. A walk with no open chain or a bad cluster gives one result
// word from the check step, with no reads.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user is bound to do so only while busy is low, which the block does not
// enforce. Reset (synchronous, active low) closes the chain and restores the
// register defaults; the FAT store is not cleared and must be loaded.
module fat_cluster_chain_walker_top #(
    parameter int FAT_STORE_BYTES    = fccw_pkg::FAT_STORE_BYTES_DEF,
    parameter int MAX_CLUSTER_BLOCKS = fccw_pkg::MAX_CLUSTER_BLOCKS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire fccw_pkg::t_item               i_item,
    output logic                               o_strobe,
    output fccw_pkg::t_result                  o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [fccw_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int MW = $clog2(FAT_STORE_BYTES);
    localparam logic [fccw_pkg::ADDR_W-1:0] FAT_LIMIT =
        fccw_pkg::ADDR_W'(FAT_STORE_BYTES);
    localparam logic [fccw_pkg::SPC_W-1:0] SPC_MAX =
        fccw_pkg::SPC_W'(MAX_CLUSTER_BLOCKS);

    // FAT byte store
    logic [7:0] mem [FAT_STORE_BYTES];
    logic [7:0] r_rd_data;

    // configuration
    logic                          r_fat16;
    logic [fccw_pkg::SPC_W-1:0]    r_spc;
    logic [fccw_pkg::CFG_W-1:0]    r_data_base;
    logic [fccw_pkg::CL_W-1:0]     r_cl_count;

    // chain state
    fccw_pkg::t_state              r_state, n_state;
    logic [fccw_pkg::CL_W-1:0]     r_cur, n_cur;
    logic [fccw_pkg::VIS_W-1:0]    r_visited, n_visited;
    logic                          r_active, n_active;

    // walk datapath
    logic [fccw_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic                          r_oob0, n_oob0;
    logic                          r_oob1, n_oob1;
    logic [7:0]                    r_lo, n_lo;
    logic [fccw_pkg::BLK_W-1:0]    r_prod, n_prod;
    logic [fccw_pkg::BLK_W-1:0]    r_block, n_block;
    logic [fccw_pkg::CL_W-1:0]     r_nxt, n_nxt;
    logic                          r_eoc, n_eoc;
    logic [fccw_pkg::SPC_W-1:0]    r_left, n_left;

    // result register
    logic                          r_strobe, n_strobe;
    fccw_pkg::t_result             r_result, n_result;

    logic                          accept;
    logic                          load_ok;
    logic [fccw_pkg::ADDR_W-1:0]   rd_addr;
    logic [fccw_pkg::SPC_W-1:0]    eff_spc;
    logic [fccw_pkg::CL_W-1:0]     cl_off;
    logic [fccw_pkg::PROD_W-1:0]   prod_c;
    logic                          cl_bad;
    logic [fccw_pkg::BLK_W-1:0]    op_a, op_b, sum;
    logic [fccw_pkg::CL_W-1:0]     raw_v, nxt_c, eoc_mask;

    assign accept  = start && !busy;
    assign load_ok = ({1'b0, i_item.byte_address} < FAT_LIMIT);
    assign busy    = (r_state != fccw_pkg::ST_IDLE);

    // clamp of cluster size to 1..MAX_CLUSTER_BLOCKS
    always_comb begin
        if (r_spc == '0) begin
            eff_spc = fccw_pkg::SPC_W'(1);
        end else if (r_spc > SPC_MAX) begin
            eff_spc = SPC_MAX;
        end else begin
            eff_spc = r_spc;
        end
    end

    // cluster validity and base product
    assign cl_off = r_cur - fccw_pkg::CL_W'(2);
    assign cl_bad = (r_cur < fccw_pkg::CL_W'(2)) || (cl_off >= r_cl_count) ||
                    (r_visited >= {1'b0, r_cl_count});
    assign prod_c = {{fccw_pkg::SPC_W{1'b0}}, cl_off} *
                    {{fccw_pkg::CL_W{1'b0}}, eff_spc};

    // next FAT entry from the two bytes
    assign raw_v    = {r_oob1 ? 8'h00 : r_rd_data, r_lo};
    assign eoc_mask = r_fat16 ? fccw_pkg::EOC_MASK16 : fccw_pkg::EOC_MASK12;
    always_comb begin
        if (r_fat16) begin
            nxt_c = raw_v & fccw_pkg::ENTRY_MASK16;
        end else if (r_cur[0]) begin
            nxt_c = (raw_v >> 4) & fccw_pkg::ENTRY_MASK12;
        end else begin
            nxt_c = raw_v & fccw_pkg::ENTRY_MASK12;
        end
    end

    // shared adder operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            fccw_pkg::ST_CHECK: begin
                op_a = fccw_pkg::BLK_W'({r_cur, 1'b0});
                op_b = r_fat16 ? '0 : fccw_pkg::BLK_W'(r_cur);
            end
            fccw_pkg::ST_RD1: begin
                op_a = fccw_pkg::BLK_W'(r_addr);
                op_b = fccw_pkg::BLK_W'(1);
            end
            fccw_pkg::ST_RD2: begin
                op_a = r_prod;
                op_b = fccw_pkg::BLK_W'(r_data_base);
            end
            fccw_pkg::ST_EMIT: begin
                op_a = r_block;
                op_b = fccw_pkg::BLK_W'(1);
            end
            fccw_pkg::ST_IDLE: begin
                op_a = '0;
                op_b = '0;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end
    assign sum = op_a + op_b;

    // read address: first byte from the check step, second from the read step
    always_comb begin
        if (r_state == fccw_pkg::ST_CHECK) begin
            rd_addr = r_fat16 ? sum[fccw_pkg::ADDR_W-1:0]
                              : {1'b0, sum[fccw_pkg::ADDR_W-1:1]};
        end else begin
            rd_addr = sum[fccw_pkg::ADDR_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_visited = r_visited;
        n_active  = r_active;
        n_addr    = r_addr;
        n_oob0    = r_oob0;
        n_oob1    = r_oob1;
        n_lo      = r_lo;
        n_prod    = r_prod;
        n_block   = r_block;
        n_nxt     = r_nxt;
        n_eoc     = r_eoc;
        n_left    = r_left;
        n_strobe  = 1'b0;
        n_result  = r_result;
        unique case (r_state)
            fccw_pkg::ST_IDLE: begin
                if (accept && i_item.kind == fccw_pkg::KIND_START) begin
                    n_cur     = i_item.start_cluster;
                    n_visited = '0;
                    n_active  = 1'b1;
                    n_state   = fccw_pkg::ST_CHECK;
                end else if (accept && i_item.kind == fccw_pkg::KIND_CONT) begin
                    n_state = fccw_pkg::ST_CHECK;
                end
            end
            fccw_pkg::ST_CHECK: begin
                if (!r_active) begin
                    n_strobe = 1'b1;
                    n_result = '{block_number: '0, status: fccw_pkg::STAT_NO_CHAIN,
                                 end_of_chain: 1'b0, last_of_run: 1'b1};
                    n_state  = fccw_pkg::ST_IDLE;
                end else if (cl_bad) begin
                    n_active = 1'b0;
                    n_strobe = 1'b1;
                    n_result = '{block_number: '0, status: fccw_pkg::STAT_BAD,
                                 end_of_chain: 1'b0, last_of_run: 1'b1};
                    n_state  = fccw_pkg::ST_IDLE;
                end else begin
                    n_addr  = rd_addr;
                    n_oob0  = (rd_addr >= FAT_LIMIT);
                    n_prod  = fccw_pkg::BLK_W'(prod_c);
                    n_state = fccw_pkg::ST_RD1;
                end
            end
            fccw_pkg::ST_RD1: begin
                n_lo    = r_oob0 ? 8'h00 : r_rd_data;
                n_oob1  = (rd_addr >= FAT_LIMIT);
                n_state = fccw_pkg::ST_RD2;
            end
            fccw_pkg::ST_RD2: begin
                n_nxt   = nxt_c;
                n_eoc   = ((nxt_c & eoc_mask) == eoc_mask);
                n_block = sum;
                n_left  = eff_spc - fccw_pkg::SPC_W'(1);
                n_state = fccw_pkg::ST_EMIT;
            end
            fccw_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                n_result = '{block_number: r_block, status: fccw_pkg::STAT_OK,
                             end_of_chain: r_eoc, last_of_run: (r_left == '0)};
                n_block  = sum;
                n_left   = r_left - fccw_pkg::SPC_W'(1);
                if (r_left == '0) begin
                    n_visited = r_visited + fccw_pkg::VIS_W'(1);
                    n_cur     = r_nxt;
                    if (r_eoc) begin
                        n_active = 1'b0;
                    end
                    n_state = fccw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fccw_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fccw_pkg::ST_IDLE;
            r_cur     <= '0;
            r_visited <= '0;
            r_active  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_visited <= n_visited;
            r_active  <= n_active;
            r_strobe  <= n_strobe;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_oob0   <= n_oob0;
        r_oob1   <= n_oob1;
        r_lo     <= n_lo;
        r_prod   <= n_prod;
        r_block  <= n_block;
        r_nxt    <= n_nxt;
        r_eoc    <= n_eoc;
        r_left   <= n_left;
        r_result <= n_result;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat16     <= 1'b0;
            r_spc       <= fccw_pkg::SPC_W'(1);
            r_data_base <= '0;
            r_cl_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fccw_pkg::CFG_FAT16:     r_fat16     <= i_cfg_data[0];
                fccw_pkg::CFG_SPC:       r_spc       <= i_cfg_data[fccw_pkg::SPC_W-1:0];
                fccw_pkg::CFG_DATA_BASE: r_data_base <= i_cfg_data;
                fccw_pkg::CFG_CL_COUNT:  r_cl_count  <= i_cfg_data[fccw_pkg::CL_W-1:0];
                default:                 r_fat16     <= r_fat16;
            endcase
        end
    end

    // FAT store write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == fccw_pkg::KIND_LOAD && load_ok) begin
            mem[i_item.byte_address[MW-1:0]] <= i_item.byte_value;
        end
        r_rd_data <= mem[rd_addr[MW-1:0]];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // a result word only follows a check or emit step
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == fccw_pkg::ST_CHECK ||
                      $past(r_state) == fccw_pkg::ST_EMIT))
        else $error("result word without check or emit step");

    // the block is free again once the final word of a walk is out
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |-> !busy)
        else $error("still busy after final result word");

    // error words are single and carry no block
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != fccw_pkg::STAT_OK) |->
            (o_result.last_of_run && o_result.block_number == '0))
        else $error("error word malformed");

    // blocks within one cluster run consecutively
    a_consecutive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && !$past(o_result.last_of_run)) |->
            (o_result.block_number ==
             fccw_pkg::BLK_W'($past(o_result.block_number) + fccw_pkg::BLK_W'(1))))
        else $error("block numbers not consecutive");
`endif

endmodule

`default_nettype wire

// ===== test/fat_cluster_chain_walker_top_tb.sv =====
`timescale 1ns / 1ps

module fat_cluster_chain_walker_top_tb;
    import fccw_pkg::*;

    localparam int FAT_BYTES    = FAT_STORE_BYTES_DEF;
    localparam int MAX_RUN      = MAX_CLUSTER_BLOCKS_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WALKS = 20;

    // block ports
    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_item             i_item      = '0;
    logic              o_strobe;
    t_result           o_result;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_index = CFG_FAT16;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    // shadow of the fat store and of the walker
    bit   [7:0]        fat_image [FAT_BYTES];
    bit                fat_known [FAT_BYTES];
    logic [CL_W-1:0]   walk_cluster  = '0;
    logic [VIS_W-1:0]  walk_visited  = '0;
    logic              walk_open     = 1'b0;
    logic              reg_fat16     = 1'b0;
    logic [SPC_W-1:0]  reg_spc       = 7'd1;
    logic [CFG_W-1:0]  reg_data_base = '0;
    logic [CL_W-1:0]   reg_cl_count  = '0;

    t_result           pending_blocks [$];
    logic [CL_W-1:0]   chain_links [$];

    int                mismatch_count = 0;
    int                cycle_count    = 0;
    int                walks_sent     = 0;
    int                burst_left     = 0;
    bit                sender_gaps    = 1'b0;

    fat_cluster_chain_walker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fat_cluster_chain_walker_top_tb: done, errors");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        mismatch_count++;
    endtask

    // result checker, compares against the oldest expected block
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                note_mismatch("strobe unknown");
            end else if (o_strobe) begin
                if (pending_blocks.size() == 0) begin
                    note_mismatch($sformatf("unexpected word %h", o_result));
                end else begin
                    want = pending_blocks.pop_front();
                    if (o_result.block_number !== want.block_number)
                        note_mismatch($sformatf("block_number %h, want %h",
                            o_result.block_number, want.block_number));
                    if (o_result.status !== want.status)
                        note_mismatch($sformatf("status %h, want %h",
                            o_result.status, want.status));
                    if (o_result.end_of_chain !== want.end_of_chain)
                        note_mismatch($sformatf("end_of_chain %b, want %b (block %h)",
                            o_result.end_of_chain, want.end_of_chain, want.block_number));
                    if (o_result.last_of_run !== want.last_of_run)
                        note_mismatch($sformatf("last_of_run %b, want %b (block %h)",
                            o_result.last_of_run, want.last_of_run, want.block_number));
                end
            end
        end
    end

    function automatic logic [7:0] fat_byte(input int unsigned at);
        return (at < FAT_BYTES) ? fat_image[at] : 8'h00;
    endfunction

    // byte offset of a cluster's fat entry in the current mode
    function automatic int unsigned entry_offset(input logic [CL_W-1:0] cl);
        return reg_fat16 ? 32'(cl) * 2 : (32'(cl) * 3) >> 1;
    endfunction

    function automatic logic [CL_W-1:0] fat_next_cluster(input logic [CL_W-1:0] cl);
        int unsigned at;
        logic [15:0] pair;
        at = entry_offset(cl);
        pair = {fat_byte(at + 1), fat_byte(at)};
        if (reg_fat16)
            return pair;
        if (cl[0])
            pair = pair >> 4;
        return pair & ENTRY_MASK12;
    endfunction

    function automatic bit cluster_ok(input logic [CL_W-1:0] cl, input logic [VIS_W-1:0] seen);
        return cl >= 2 && (32'(cl) - 32'd2) < 32'(reg_cl_count) && seen < reg_cl_count;
    endfunction

    // blocks of the current cluster, then step to the next one
    task automatic predict_cluster_blocks();
        int unsigned spc;
        int unsigned base;
        int unsigned i;
        logic [CL_W-1:0] nxt;
        logic [CL_W-1:0] mask;
        logic eoc;
        t_result r;
        r = '0;
        r.last_of_run = 1'b1;
        if (!walk_open) begin
            r.status = STAT_NO_CHAIN;
            pending_blocks.push_back(r);
        end else if (!cluster_ok(walk_cluster, walk_visited)) begin
            r.status = STAT_BAD;
            pending_blocks.push_back(r);
            walk_open = 1'b0;
        end else begin
            spc = (reg_spc == 0) ? 1 : (reg_spc > MAX_RUN) ? MAX_RUN : 32'(reg_spc);
            nxt = fat_next_cluster(walk_cluster);
            mask = reg_fat16 ? EOC_MASK16 : EOC_MASK12;
            eoc = ((nxt & mask) == mask);
            base = (32'(walk_cluster) - 32'd2) * spc + 32'(reg_data_base);
            for (i = 0; i < spc; i++) begin
                r.block_number = BLK_W'(base + i);
                r.status       = STAT_OK;
                r.end_of_chain = eoc;
                r.last_of_run  = (i + 1 == spc);
                pending_blocks.push_back(r);
            end
            walk_visited = walk_visited + 1'b1;
            walk_cluster = nxt;
            if (eoc)
                walk_open = 1'b0;
        end
    endtask

    // shadow update for a word the block has taken
    task automatic predict_word(input t_item w);
        case (w.kind)
            KIND_LOAD: begin
                fat_image[w.byte_address] = w.byte_value;
                fat_known[w.byte_address] = 1'b1;
            end
            KIND_START: begin
                walk_cluster = w.start_cluster;
                walk_visited = '0;
                walk_open    = 1'b1;
                predict_cluster_blocks();
            end
            KIND_CONT: predict_cluster_blocks();
            default: ;
        endcase
    endtask

    function automatic t_item noisy_word(input logic [1:0] kind);
        t_item w;
        w.kind          = kind;
        w.byte_address  = BADDR_W'($urandom);
        w.byte_value    = 8'($urandom);
        w.start_cluster = CL_W'($urandom);
        return w;
    endfunction

    // send one word, with burst gaps; start is left high afterwards
    task automatic send_word(input t_item w);
        int gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 1);
                gap = ($urandom_range(3, 0) == 0) ? $urandom_range(25, 6) : $urandom_range(3, 1);
            end
            burst_left--;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= w;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_word(w);
    endtask

    // start or continue a walk; fat bytes the walk reads are loaded first if unknown
    task automatic walk_word(input logic [1:0] kind, input logic [CL_W-1:0] cl);
        logic [CL_W-1:0]  at_cl;
        logic             live;
        logic [VIS_W-1:0] seen;
        int unsigned      at;
        int               k;
        t_item            w;
        if (kind == KIND_START) begin
            at_cl = cl;
            live  = 1'b1;
            seen  = '0;
        end else begin
            at_cl = walk_cluster;
            live  = walk_open;
            seen  = walk_visited;
        end
        if (live && cluster_ok(at_cl, seen)) begin
            at = entry_offset(at_cl);
            for (k = 0; k < 2; k++) begin
                if (at + k < FAT_BYTES && !fat_known[at + k]) begin
                    w = noisy_word(KIND_LOAD);
                    w.byte_address = BADDR_W'(at + k);
                    send_word(w);
                end
            end
        end
        w = noisy_word(kind);
        w.start_cluster = cl;
        send_word(w);
        walks_sent++;
    endtask

    // write one fat entry, keeping the neighbor nibble in 12-bit mode
    task automatic write_fat_entry(input logic [CL_W-1:0] cl, input logic [CL_W-1:0] value);
        int unsigned at;
        logic [15:0] pair;
        t_item w;
        at = entry_offset(cl);
        if (reg_fat16) begin
            pair = value;
        end else begin
            pair = {fat_image[at + 1], fat_image[at]};
            if (cl[0])
                pair = {value[11:0], pair[3:0]};
            else
                pair = {pair[15:12], value[11:0]};
        end
        w = noisy_word(KIND_LOAD);
        w.byte_address = BADDR_W'(at);
        w.byte_value   = pair[7:0];
        send_word(w);
        w.byte_address = BADDR_W'(at + 1);
        w.byte_value   = pair[15:8];
        send_word(w);
    endtask

    // link chain_links in order, the last one pointing at tail
    task automatic load_chain(input logic [CL_W-1:0] tail);
        int k;
        for (k = 0; k < chain_links.size(); k++)
            write_fat_entry(chain_links[k], (k + 1 < chain_links.size()) ? chain_links[k + 1] : tail);
    endtask

    task automatic follow_chain(input logic [CL_W-1:0] first, input int max_walks);
        int n;
        walk_word(KIND_START, first);
        n = 1;
        while (walk_open && n < max_walks) begin
            walk_word(KIND_CONT, CL_W'($urandom));
            n++;
        end
    endtask

    // hold off until every expected block is in, then let the block settle
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // all four registers on back-to-back cycles, junk in the unused data bits
    task automatic set_config(input logic f16, input logic [SPC_W-1:0] spc,
                              input logic [CFG_W-1:0] base, input logic [CL_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FAT16;
        i_cfg_data  <= {23'($urandom), f16};
        @(posedge i_clk);
        i_cfg_index <= CFG_SPC;
        i_cfg_data  <= {17'($urandom), spc};
        @(posedge i_clk);
        i_cfg_index <= CFG_DATA_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_CL_COUNT;
        i_cfg_data  <= {8'($urandom), count};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_fat16     = f16;
        reg_spc       = spc;
        reg_data_base = base;
        reg_cl_count  = count;
    endtask

    function automatic logic [CL_W-1:0] pick_cluster();
        int unsigned top;
        top = 32'(reg_cl_count) + 1;
        if (!reg_fat16 && top > 4087)
            top = 4087;
        if (reg_cl_count == 0)
            return 16'd2;
        return CL_W'($urandom_range(top, 2));
    endfunction

    // walks with reset settings: no chain, unused kind, zero cluster count
    task automatic test_no_chain();
        walk_word(KIND_CONT, 16'hffff);
        send_word(noisy_word(2'd3));
        walk_word(KIND_START, 16'd0);
        walk_word(KIND_CONT, 16'd0);
    endtask

    // 12-bit entries, even and odd clusters, highest data base
    task automatic test_fat12_chain();
        wait_drained();
        set_config(1'b0, 7'd3, 24'hffffff, 16'd20);
        chain_links = '{16'd2, 16'd3, 16'd21};
        load_chain(EOC_MASK12 | 16'h7);
        follow_chain(16'd2, 4);
        walk_word(KIND_CONT, 16'd0);
        // lowest end marker on the first cluster
        chain_links = '{16'd6};
        load_chain(EOC_MASK12);
        follow_chain(16'd6, 2);
        // just past the last cluster, and below cluster 2
        walk_word(KIND_START, 16'd22);
        walk_word(KIND_START, 16'd1);
    endtask

    // 16-bit entries, clamped cluster sizes, largest clusters
    task automatic test_fat16_chain();
        wait_drained();
        set_config(1'b1, 7'd127, 24'd0, 16'd65525);
        chain_links = '{16'd65526, 16'd40000, 16'd2};
        load_chain(EOC_MASK16);
        follow_chain(16'd65526, 4);
        wait_drained();
        set_config(1'b1, 7'd0, 24'h5a5a5a, 16'd65525);
        chain_links = '{16'd32769};
        load_chain(16'hffff);
        follow_chain(16'd32769, 2);
        // one bit short of an end marker, lands past the last cluster
        chain_links = '{16'd12345};
        load_chain(16'hfff7);
        follow_chain(16'd12345, 3);
    endtask

    // looping chain hits the length limit, link to cluster 1
    task automatic test_bad_links();
        wait_drained();
        set_config(1'b0, 7'd2, 24'd100, 16'd4);
        chain_links = '{16'd2, 16'd3};
        load_chain(16'd2);
        follow_chain(16'd2, 8);
        chain_links = '{16'd4};
        load_chain(16'd1);
        follow_chain(16'd4, 4);
        walk_word(KIND_CONT, 16'd0);
    endtask

    // random settings per phase, mostly well-formed chains
    task automatic test_random_traffic();
        int walk_goal;
        int seq;
        int pick;
        int n;
        int k;
        logic [1:0]       kind;
        logic [SPC_W-1:0] spc;
        logic [CL_W-1:0]  count;
        logic [CL_W-1:0]  tail;
        walk_goal = walks_sent + RANDOM_WALKS;
        while (walks_sent < walk_goal) begin
            wait_drained();
            case ($urandom_range(9, 0))
                0:       spc = 7'd0;
                1:       spc = 7'd127;
                2:       spc = SPC_W'($urandom_range(64, 9));
                default: spc = SPC_W'($urandom_range(8, 1));
            endcase
            case ($urandom_range(4, 0))
                0:       count = 16'd65525;
                1:       count = CL_W'($urandom_range(6, 1));
                2:       count = CL_W'($urandom_range(65525, 0));
                default: count = CL_W'($urandom_range(3000, 8));
            endcase
            set_config(1'($urandom), spc, CFG_W'($urandom), count);
            sender_gaps = ($urandom_range(3, 0) != 0);
            for (seq = 0; seq < 6; seq++) begin
                pick = $urandom_range(9, 0);
                chain_links.delete();
                if (pick <= 5) begin
                    n = $urandom_range(5, 1);
                    for (k = 0; k < n; k++)
                        chain_links.push_back(pick_cluster());
                    load_chain((reg_fat16 ? EOC_MASK16 : EOC_MASK12) | CL_W'($urandom_range(7, 0)));
                    follow_chain(chain_links[0], n + 2);
                    if ($urandom_range(2, 0) == 0)
                        walk_word(KIND_CONT, CL_W'($urandom));
                end else if (pick == 6) begin
                    n = $urandom_range(3, 1);
                    for (k = 0; k < n; k++)
                        chain_links.push_back(pick_cluster());
                    case ($urandom_range(3, 0))
                        0:       tail = 16'd0;
                        1:       tail = 16'd1;
                        2:       tail = reg_cl_count + 16'd2;
                        default: tail = CL_W'($urandom);
                    endcase
                    load_chain(tail);
                    follow_chain(chain_links[0], n + 2);
                end else if (pick == 7 && reg_cl_count >= 2 && reg_cl_count <= 8) begin
                    chain_links.push_back(pick_cluster());
                    chain_links.push_back(pick_cluster());
                    load_chain(chain_links[0]);
                    follow_chain(chain_links[0], reg_cl_count + 3);
                end else begin
                    // loose words: stray loads, walks, unused kind
                    n = $urandom_range(4, 1);
                    for (k = 0; k < n; k++) begin
                        kind = 2'($urandom_range(3, 0));
                        if (kind == KIND_START || kind == KIND_CONT)
                            walk_word(kind, $urandom_range(1, 0) ? pick_cluster() : CL_W'($urandom));
                        else
                            send_word(noisy_word(kind));
                    end
                end
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_gaps = 1'b1;
        test_no_chain();
        test_fat12_chain();
        test_fat16_chain();
        test_bad_links();
        test_random_traffic();
        wait_drained();
        repeat (72) @(posedge i_clk);
        if (pending_blocks.size() != 0)
            note_mismatch($sformatf("%0d expected words never came", pending_blocks.size()));
        if (mismatch_count == 0)
            $display("fat_cluster_chain_walker_top_tb: done, clean");
        else
            $display("fat_cluster_chain_walker_top_tb: done, errors");
        $finish;
    end

endmodule
